@@ rtl/utf8d_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Item types, widths and lead byte constants shared by the decoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

  localparam int unsigned CountWidth   = 20;
  localparam int unsigned PendWidth    = 3;
  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned ContBits     = 6;
  localparam int unsigned PayloadWidth = 5;

  localparam logic [PendWidth-1:0] MaxPending = 3'd5;

  // Lead byte prefix masks (RFC 2279 six byte form).
  localparam logic [7:0] Lead2Mask = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF0;
  localparam logic [7:0] Lead5Mask = 8'hF8;
  localparam logic [7:0] Lead6Mask = 8'hFC;
  localparam logic [7:0] ContMask  = 8'h80;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [ValueWidth-1:0] code_point;
    logic                  truncated;
    logic                  last_char;
    logic [CountWidth-1:0] char_count;
  } out_item_t;

  typedef struct packed {
    logic [PendWidth-1:0]    need;
    logic [PayloadWidth-1:0] payload;
  } lead_info_t;

endpackage

`default_nettype wire

@@ rtl/utf8d_in_if.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder input channel
// Valid/ready channel that carries one raw byte item.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8d_in_if;
  logic                valid;
  logic                ready;
  utf8d_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/utf8d_out_if.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder output channel
// Valid/ready channel that carries one decoded character item.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8d_out_if;
  logic                 valid;
  logic                 ready;
  utf8d_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/utf8d_lead_dec.sv @@
// ----------------------------------------------------------------------------
// UTF-8 lead byte classifier
// Finds the sequence length of a lead byte and extracts its payload bits.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_lead_dec (
  input  logic [7:0]            byte_i,
  output utf8d_pkg::lead_info_t info_o
);

  always_comb begin
    info_o = '0;
    // Longest prefix wins, so 0xFE and 0xFF fall into the six byte form.
    if ((byte_i & utf8d_pkg::Lead6Mask) == utf8d_pkg::Lead6Mask) begin
      info_o.need    = 3'd5;
      info_o.payload = {4'b0, byte_i[0]};
    end else if ((byte_i & utf8d_pkg::Lead5Mask) == utf8d_pkg::Lead5Mask) begin
      info_o.need    = 3'd4;
      info_o.payload = {3'b0, byte_i[1:0]};
    end else if ((byte_i & utf8d_pkg::Lead4Mask) == utf8d_pkg::Lead4Mask) begin
      info_o.need    = 3'd3;
      info_o.payload = {2'b0, byte_i[2:0]};
    end else if ((byte_i & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Mask) begin
      info_o.need    = 3'd2;
      info_o.payload = {1'b0, byte_i[3:0]};
    end else if ((byte_i & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Mask) begin
      info_o.need    = 3'd1;
      info_o.payload = byte_i[4:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/utf8_stream_decoder_top.sv @@
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a byte stream in the six byte RFC 2279 form into code points.
// ----------------------------------------------------------------------------
// The result is registered: it is valid in the cycle after the byte that completes it.
// Throughput: one byte item per cycle; the result register is refilled in
// the same cycle it is taken, so input is stalled only by output backpressure.
// Reset clears the sequence state, the character count and the result valid.
`default_nettype none

module utf8_stream_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  utf8d_in_if.sink    in_i,
  utf8d_out_if.source out_o
);

  localparam int unsigned CW = utf8d_pkg::CountWidth;
  localparam int unsigned VW = utf8d_pkg::ValueWidth;
  localparam int unsigned PW = utf8d_pkg::PendWidth;

  logic [PW-1:0] pend_q, pend_d;
  logic [VW-1:0] value_q, value_d;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;
  utf8d_pkg::out_item_t out_item_q, out_item_d;

  utf8d_pkg::lead_info_t lead;
  logic          accept;
  logic          has_result;
  logic [7:0]    byte_in;
  logic          last_byte;
  logic [VW-1:0] cont_value;
  logic [PW-1:0] pend_dec;
  logic [CW-1:0] count_inc;

  utf8d_lead_dec u_lead_dec (
    .byte_i (byte_in),
    .info_o (lead)
  );

  assign byte_in    = in_i.data.byte_in;
  assign last_byte  = in_i.data.last_byte;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign cont_value = {value_q[VW-utf8d_pkg::ContBits-1:0], byte_in[utf8d_pkg::ContBits-1:0]};
  assign pend_dec   = pend_q - 3'd1;
  assign count_inc  = (&count_q) ? count_q : count_q + CW'(1);

  always_comb begin
    pend_d     = pend_q;
    value_d    = value_q;
    count_d    = count_q;
    has_result = 1'b0;
    out_item_d = out_item_q;

    if (accept) begin
      if (pend_q != '0) begin
        pend_d  = pend_dec;
        value_d = cont_value;
        if (pend_dec == '0) begin
          has_result = 1'b1;
          count_d    = count_inc;
          out_item_d = '{code_point: cont_value, truncated: 1'b0,
                         last_char: last_byte, char_count: count_inc};
        end
      end else if (lead.need == '0) begin
        has_result = 1'b1;
        count_d    = count_inc;
        out_item_d = '{code_point: {{(VW-8){1'b0}}, byte_in}, truncated: 1'b0,
                       last_char: last_byte, char_count: count_inc};
      end else begin
        pend_d  = lead.need;
        value_d = {{(VW-utf8d_pkg::PayloadWidth){1'b0}}, lead.payload};
      end

      // A string that ends with a sequence still open is reported as truncated.
      if (last_byte && !has_result) begin
        has_result = 1'b1;
        out_item_d = '{code_point: '0, truncated: 1'b1,
                       last_char: 1'b1, char_count: count_q};
      end

      if (last_byte) begin
        pend_d  = '0;
        value_d = '0;
        count_d = '0;
      end
    end

    if (has_result) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      value_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      value_q     <= value_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (has_result) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= utf8d_pkg::MaxPending)
    else $error("pending continuation count out of range");

  a_string_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_byte |=> pend_q == '0 && count_q == '0 && value_q == '0)
    else $error("state not cleared after last byte of string");

  a_trunc_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.truncated |->
      out_item_q.code_point == '0 && out_item_q.last_char)
    else $error("truncation result malformed");

  a_char_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_item_q.truncated |-> out_item_q.char_count != '0)
    else $error("character result with zero count");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("input taken while result is stalled");

endmodule

`default_nettype wire

@@ test/utf8_stream_decoder_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Sends byte strings with random pacing and checks every decoded character
// against an in-bench prediction of the six byte decoder.
// ----------------------------------------------------------------------------

module utf8_stream_decoder_top_tb;

  // Predicts the decoded characters and compares them as they come out.
  class utf8_char_scoreboard;
    utf8d_pkg::out_item_t             expected_q[$];
    logic [utf8d_pkg::PendWidth-1:0]  pend_bytes;
    logic [utf8d_pkg::ValueWidth-1:0] acc_value;
    logic [utf8d_pkg::CountWidth-1:0] char_total;
    int unsigned                      bytes_seen;
    int unsigned                      chars_checked;
    int unsigned                      truncations;
    int unsigned                      failures;

    function new();
      clear_string();
      bytes_seen    = 0;
      chars_checked = 0;
      truncations   = 0;
      failures      = 0;
    endfunction

    function void clear_string();
      pend_bytes = '0;
      acc_value  = '0;
      char_total = '0;
    endfunction

    function void push_char(logic [utf8d_pkg::ValueWidth-1:0] value, logic last);
      utf8d_pkg::out_item_t e;
      if (char_total != {utf8d_pkg::CountWidth{1'b1}}) char_total++;
      e.code_point = value;
      e.truncated  = 1'b0;
      e.last_char  = last;
      e.char_count = char_total;
      expected_q.push_back(e);
      if (last) clear_string();
    endfunction

    function void note_byte(utf8d_pkg::in_item_t item);
      logic [7:0]                      b;
      logic [utf8d_pkg::PendWidth-1:0] need;
      logic [7:0]                      lead_mask;
      utf8d_pkg::out_item_t            e;
      b = item.byte_in;
      bytes_seen++;
      if (pend_bytes != 0) begin
        acc_value = {acc_value[utf8d_pkg::ValueWidth-utf8d_pkg::ContBits-1:0],
                     b[utf8d_pkg::ContBits-1:0]};
        pend_bytes--;
        if (pend_bytes == 0) begin
          push_char(acc_value, item.last_byte);
          return;
        end
      end else begin
        if ((b & utf8d_pkg::Lead6Mask) == utf8d_pkg::Lead6Mask) begin
          need = 3'd5; lead_mask = utf8d_pkg::Lead6Mask;
        end else if ((b & utf8d_pkg::Lead5Mask) == utf8d_pkg::Lead5Mask) begin
          need = 3'd4; lead_mask = utf8d_pkg::Lead5Mask;
        end else if ((b & utf8d_pkg::Lead4Mask) == utf8d_pkg::Lead4Mask) begin
          need = 3'd3; lead_mask = utf8d_pkg::Lead4Mask;
        end else if ((b & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Mask) begin
          need = 3'd2; lead_mask = utf8d_pkg::Lead3Mask;
        end else if ((b & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Mask) begin
          need = 3'd1; lead_mask = utf8d_pkg::Lead2Mask;
        end else begin
          push_char({{(utf8d_pkg::ValueWidth-8){1'b0}}, b}, item.last_byte);
          return;
        end
        // The payload is everything below the bit that follows the prefix,
        // so a 6-byte lead keeps only bit 0.
        pend_bytes = need;
        acc_value  = {{(utf8d_pkg::ValueWidth-8){1'b0}}, b & ~{1'b1, lead_mask[7:1]}};
      end
      if (item.last_byte) begin
        e.code_point = '0;
        e.truncated  = 1'b1;
        e.last_char  = 1'b1;
        e.char_count = char_total;
        expected_q.push_back(e);
        clear_string();
      end
    endfunction

    function void check_result(utf8d_pkg::out_item_t got);
      utf8d_pkg::out_item_t e;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected character cp=%h trunc=%b last=%b count=%0d",
                   $realtime, got.code_point, got.truncated, got.last_char,
                   got.char_count);
        return;
      end
      e = expected_q.pop_front();
      chars_checked++;
      if (e.truncated) truncations++;
      if (got.code_point !== e.code_point || got.truncated !== e.truncated ||
          got.last_char !== e.last_char || got.char_count !== e.char_count) begin
        failures++;
        if (failures <= 10)
          $display({"%0t: mismatch exp cp=%h trunc=%b last=%b count=%0d",
                    " / got cp=%h trunc=%b last=%b count=%0d"},
                   $realtime, e.code_point, e.truncated, e.last_char, e.char_count,
                   got.code_point, got.truncated, got.last_char, got.char_count);
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  utf8d_in_if  in_if ();
  utf8d_out_if out_if ();

  utf8_stream_decoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  utf8_char_scoreboard sb;
  logic [7:0]  str_q[$];
  int unsigned burst_left;
  int unsigned strings_sent;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    out_if.ready  = 1'b0;
  end

  // Both channels are sampled here, input first, so an item accepted at the
  // same edge as a result is always predicted before the result is checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_byte(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
    end
  end

  // Receiver: switches between four stall modes, each held for a random span.
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned phase;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(negedge clk_i);
        phase++;
        case (mode)
          0: begin
            out_if.ready = 1'b1;
          end
          1: begin
            out_if.ready = ($urandom_range(0, 3) != 0);
          end
          2: begin
            out_if.ready = ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_if.ready = (phase % 5 != 0);
          end
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk_i);
    in_if.valid          = 1'b1;
    in_if.data.byte_in   = b;
    in_if.data.last_byte = last;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic idle_cycles(input int unsigned n);
    @(negedge clk_i);
    in_if.valid = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic send_string();
    for (int i = 0; i < str_q.size(); i++) begin
      send_byte(str_q[i], i == str_q.size() - 1);
      if (burst_left == 0) begin
        idle_cycles($urandom_range(1, 6));
        burst_left = $urandom_range(1, 40);
      end else begin
        burst_left--;
      end
    end
    strings_sent++;
  endtask

  function automatic logic [7:0] lead_byte(input int unsigned len);
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    case (len)
      2:       lead_byte = utf8d_pkg::Lead2Mask | (r & 8'h1F);
      3:       lead_byte = utf8d_pkg::Lead3Mask | (r & 8'h0F);
      4:       lead_byte = utf8d_pkg::Lead4Mask | (r & 8'h07);
      5:       lead_byte = utf8d_pkg::Lead5Mask | (r & 8'h03);
      default: lead_byte = utf8d_pkg::Lead6Mask | (r & 8'h03);
    endcase
  endfunction

  // Mostly well-formed sequences; some continuation bytes carry a wrong
  // prefix and some strings stop inside a sequence.
  function automatic void build_string();
    int unsigned nchars;
    int unsigned len;
    int unsigned conts;
    bit          noisy;
    str_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      nchars = $urandom_range(1, 8);
      repeat (nchars) str_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    nchars = $urandom_range(1, 10);
    for (int i = 0; i < nchars; i++) begin
      len   = $urandom_range(1, 6);
      noisy = ($urandom_range(0, 9) == 0);
      if (len == 1) begin
        str_q.push_back(8'($urandom_range(0, 8'hBF)));
      end else begin
        str_q.push_back(lead_byte(len));
        conts = len - 1;
        if (i == nchars - 1 && $urandom_range(0, 7) == 0) conts = $urandom_range(0, len - 2);
        repeat (conts) begin
          if (noisy) str_q.push_back(8'($urandom_range(0, 255)));
          else str_q.push_back(utf8d_pkg::ContMask | (8'($urandom_range(0, 255)) & 8'h3F));
        end
      end
    end
  endfunction

  initial begin
    burst_left   = 0;
    strings_sent = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Single bytes at the edges, including the 0x80..0xBF pass-through range.
    str_q = '{8'h00, 8'h7F, 8'h80, 8'hBF};
    send_string();
    // Largest 2-byte and 3-byte values, the string ending on a completed char.
    str_q = '{8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF};
    send_string();
    // 0xFE as a 6-byte lead; lead-like bytes inside it count as continuations.
    str_q = '{8'hFE, 8'hFF, 8'hFC, 8'hC0, 8'h80, 8'h7F};
    send_string();
    // Largest 4-byte value, then a 5-byte form ending the string.
    str_q = '{8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hF8, 8'h80, 8'h80, 8'h80, 8'h80};
    send_string();
    // 0xFF alone: the string ends right after a lead.
    str_q = '{8'hFF};
    send_string();
    wait_for_drain();

    while (sb.bytes_seen < 1100) begin
      build_string();
      send_string();
      if ($urandom_range(0, 29) == 0) wait_for_drain();
    end
    wait_for_drain();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d strings, %0d bytes; checked %0d characters, %0d of them truncations.",
             strings_sent, sb.bytes_seen, sb.chars_checked, sb.truncations);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("** utf8_stream_decoder_top: PASSED **");
    end else begin
      $display("%0d failures, %0d characters still awaited.", sb.failures, sb.outstanding());
      $display("** utf8_stream_decoder_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timeout with %0d characters still awaited.", sb.outstanding());
    $display("** utf8_stream_decoder_top: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/utf8d_pkg.sv
rtl/utf8d_in_if.sv
rtl/utf8d_out_if.sv
rtl/utf8d_lead_dec.sv
rtl/utf8_stream_decoder_top.sv
test/utf8_stream_decoder_top_tb.sv
